// ===== hdl/vhfs_pkg.sv =====
// ----------------------------------------------------------------------------
// vhfs_pkg
// Shared types and constants for the video header frame sequencer.
// ----------------------------------------------------------------------------
package vhfs_pkg;

    localparam int unsigned HEADER_BYTES = 28;
    localparam int unsigned HDR_BITS     = HEADER_BYTES * 8;
    localparam int unsigned HCNT_W       = 5;
    localparam logic [HCNT_W-1:0] HCNT_LAST = HCNT_W'(HEADER_BYTES - 1);

    localparam logic [31:0] HDR_MAGIC = 32'h3056_334D;
    localparam logic [31:0] MS_PER_S  = 32'd1000;
    localparam logic [31:0] TS_MAX    = 32'hFFFF_FFFF;

    // index * 1000 * den stays below 2^74; 1000 * den below 2^42
    localparam int unsigned ACC_W  = 74;
    localparam int unsigned STEP_W = 42;

    typedef enum logic [1:0] {
        OP_HDR   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLOSE = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_PENDING     = 3'd0,
        ST_OK          = 3'd1,
        ST_INVALID     = 3'd2,
        ST_UNSUPPORTED = 3'd3,
        ST_CORRUPT     = 3'd4,
        ST_OVERFLOW    = 3'd5,
        ST_WRONG       = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        CFG_STREAM_SIZE = 2'd0,
        CFG_RGBA8_CODE  = 2'd1,
        CFG_ANY_CODE    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_status     status;
        logic        has_frame;
        logic [63:0] frame_offset;
        logic [63:0] frame_bytes;
        logic [31:0] frame_width;
        logic [31:0] frame_height;
        logic [31:0] frame_msec;
    } t_result;

endpackage

// ===== hdl/vhfs_in_if.sv =====
// ----------------------------------------------------------------------------
// vhfs_in_if
// Command channel: header bytes, frame reads and close requests.
// ----------------------------------------------------------------------------
interface vhfs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

// ===== hdl/vhfs_out_if.sv =====
// ----------------------------------------------------------------------------
// vhfs_out_if
// Result channel: status and frame descriptor, one beat per command.
// ----------------------------------------------------------------------------
interface vhfs_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        has_frame;
    logic [63:0] frame_offset;
    logic [63:0] frame_bytes;
    logic [31:0] frame_width;
    logic [31:0] frame_height;
    logic [31:0] frame_msec;

    modport source (output valid, output status, output has_frame, output frame_offset,
                    output frame_bytes, output frame_width, output frame_height,
                    output frame_msec, input ready);
    modport sink   (input valid, input status, input has_frame, input frame_offset,
                    input frame_bytes, input frame_width, input frame_height,
                    input frame_msec, output ready);
endinterface

// ===== hdl/video_header_frame_sequencer.sv =====
// ----------------------------------------------------------------------------
// video_header_frame_sequencer
// Parses a 28-byte raw RGBA container header and hands out frame descriptors.
// ----------------------------------------------------------------------------
// One command beat in, one result beat out. A header byte goes from idle straight
// to emit; the 28th byte (verdict) steps a single 32x32 multiplier through
// width*height, the two halves of frame_bytes*count and den*1000 in S_WH, S_LO,
// S_HI and S_SUM, then checks in S_CHK. A frame read runs the restoring divider
// that retires one quotient bit per cycle for the timestamp; a saturated
// timestamp, a read past the last frame, close and any rejected command go
// straight to emit. The next command is taken once the result sits in the output
// register, even if the sink has not taken it yet. Frame offset and the timestamp
// dividend are kept as running sums, so no multiply sits on the read path.
module video_header_frame_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    vhfs_in_if.sink           i_in,
    vhfs_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [63:0]       i_cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_WH   = 8'b0000_0010,
        S_LO   = 8'b0000_0100,
        S_HI   = 8'b0000_1000,
        S_SUM  = 8'b0001_0000,
        S_CHK  = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [63:0] r_stream_size;
    logic [31:0] r_rgba8_code;
    logic [31:0] r_any_code;

    // header capture
    logic [vhfs_pkg::HCNT_W-1:0]   r_hcnt;
    logic [vhfs_pkg::HDR_BITS-1:0] r_hdr;

    // open stream state
    logic                        r_open;
    logic [31:0]                 r_width, r_height, r_num, r_total, r_next;
    logic [63:0]                 r_fbytes;
    logic [63:0]                 r_offset;
    logic [vhfs_pkg::ACC_W-1:0]  r_acc;
    logic [vhfs_pkg::STEP_W-1:0] r_step;

    // verdict datapath
    logic [63:0] r_prod;
    logic [63:0] r_fb;
    logic [63:0] r_plo;
    logic [63:0] r_tot;
    logic        r_pix_ovf;
    logic        r_tot_ovf;

    // divider
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [4:0]  r_dcnt;

    // staging and output
    vhfs_pkg::t_result r_res, n_res;
    vhfs_pkg::t_result r_out;
    logic              r_out_valid;

    // header words, little endian
    logic [31:0] w_magic, w_width, w_height, w_fmt, w_num, w_den, w_cnt;
    assign w_magic  = r_hdr[31:0];
    assign w_width  = r_hdr[63:32];
    assign w_height = r_hdr[95:64];
    assign w_fmt    = r_hdr[127:96];
    assign w_num    = r_hdr[159:128];
    assign w_den    = r_hdr[191:160];
    assign w_cnt    = r_hdr[223:192];

    logic in_acc;
    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    always_comb begin
        case (r_state)
            S_WH:    begin mul_a = w_width;               mul_b = w_height;          end
            S_LO:    begin mul_a = {r_prod[29:0], 2'b00}; mul_b = w_cnt;             end
            S_HI:    begin mul_a = r_fb[63:32];           mul_b = w_cnt;             end
            S_SUM:   begin mul_a = w_den;                 mul_b = vhfs_pkg::MS_PER_S; end
            default: begin mul_a = '0;                    mul_b = '0;                end
        endcase
    end
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // total = fb_lo*cnt + (fb_hi*cnt << 32)
    logic [64:0] tot_sum;
    assign tot_sum = {1'b0, r_plo} + {1'b0, r_prod[31:0], 32'd0};

    // exact size check: header plus payload, 65 bits wide
    logic [64:0] need;
    assign need = {1'b0, r_tot} + 65'(vhfs_pkg::HEADER_BYTES);

    logic zero_field, fmt_bad, size_short;
    assign zero_field = (w_width == '0) || (w_height == '0) || (w_cnt == '0)
                     || (w_num == '0) || (w_den == '0);
    assign fmt_bad    = (w_fmt != r_rgba8_code) && (w_fmt != r_any_code);
    assign size_short = r_stream_size < 64'(vhfs_pkg::HEADER_BYTES);

    // divider step
    logic [32:0] div_t;
    logic [32:0] div_d;
    logic        div_ge;
    assign div_t  = {r_rem, r_quo[31]};
    assign div_d  = div_t - {1'b0, r_num};
    assign div_ge = div_t >= {1'b0, r_num};

    logic ts_sat;
    assign ts_sat = r_acc[vhfs_pkg::ACC_W-1:32] >= (vhfs_pkg::ACC_W - 32)'(r_num);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_size <= '0;
            r_rgba8_code  <= 32'd1;
            r_any_code    <= '0;
        end else if (i_cfg_we) begin
            unique case (vhfs_pkg::t_cfg_idx'(i_cfg_idx))
                vhfs_pkg::CFG_STREAM_SIZE: r_stream_size <= i_cfg_data;
                vhfs_pkg::CFG_RGBA8_CODE:  r_rgba8_code  <= i_cfg_data[31:0];
                vhfs_pkg::CFG_ANY_CODE:    r_any_code    <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    logic out_free;
    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EMIT;
                    if (vhfs_pkg::t_op'(i_in.operation) == vhfs_pkg::OP_HDR && !r_open
                        && r_hcnt == vhfs_pkg::HCNT_LAST) begin
                        n_state = S_WH;
                    end else if (vhfs_pkg::t_op'(i_in.operation) == vhfs_pkg::OP_READ
                                 && r_open && r_next < r_total && !ts_sat) begin
                        n_state = S_DIV;
                    end
                end
            end
            S_WH:   n_state = S_LO;
            S_LO:   n_state = S_HI;
            S_HI:   n_state = S_SUM;
            S_SUM:  n_state = S_CHK;
            S_CHK:  n_state = S_EMIT;
            S_DIV: begin
                if (r_dcnt == 5'd31) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // staged result: command decode while idle, verdict in the check state
    always_comb begin
        n_res        = '0;
        n_res.status = vhfs_pkg::ST_WRONG;
        if (r_state == S_CHK) begin
            if (size_short) begin
                n_res.status = vhfs_pkg::ST_INVALID;
            end else if (w_magic != vhfs_pkg::HDR_MAGIC) begin
                n_res.status = vhfs_pkg::ST_UNSUPPORTED;
            end else if (zero_field) begin
                n_res.status = vhfs_pkg::ST_CORRUPT;
            end else if (fmt_bad) begin
                n_res.status = vhfs_pkg::ST_UNSUPPORTED;
            end else if (r_pix_ovf || r_tot_ovf) begin
                n_res.status = vhfs_pkg::ST_OVERFLOW;
            end else if ({1'b0, r_stream_size} < need) begin
                n_res.status = vhfs_pkg::ST_CORRUPT;
            end else begin
                n_res.status       = vhfs_pkg::ST_OK;
                n_res.frame_bytes  = r_fb;
                n_res.frame_width  = w_width;
                n_res.frame_height = w_height;
            end
        end else begin
            case (vhfs_pkg::t_op'(i_in.operation))
                vhfs_pkg::OP_HDR: begin
                    if (!r_open) begin
                        n_res.status = vhfs_pkg::ST_PENDING;
                    end
                end
                vhfs_pkg::OP_READ: begin
                    if (r_open) begin
                        n_res.status = vhfs_pkg::ST_OK;
                        if (r_next < r_total) begin
                            n_res.has_frame    = 1'b1;
                            n_res.frame_offset = r_offset;
                            n_res.frame_bytes  = r_fbytes;
                            n_res.frame_width  = r_width;
                            n_res.frame_height = r_height;
                            n_res.frame_msec   = vhfs_pkg::TS_MAX;
                        end
                    end
                end
                vhfs_pkg::OP_CLOSE: begin
                    if (r_open) begin
                        n_res.status = vhfs_pkg::ST_OK;
                    end
                end
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hcnt      <= '0;
            r_open      <= 1'b0;
            r_next      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_IDLE && in_acc) begin
                case (vhfs_pkg::t_op'(i_in.operation))
                    vhfs_pkg::OP_HDR: begin
                        if (!r_open) begin
                            r_hcnt <= (r_hcnt == vhfs_pkg::HCNT_LAST) ? '0 : r_hcnt + 1'b1;
                        end
                    end
                    vhfs_pkg::OP_READ: begin
                        if (r_open && r_next < r_total) begin
                            r_next <= r_next + 1'b1;
                        end
                    end
                    vhfs_pkg::OP_CLOSE: begin
                        if (r_open) begin
                            r_open <= 1'b0;
                            r_next <= '0;
                        end
                    end
                    default: ;
                endcase
            end
            if (r_state == S_CHK && !size_short && w_magic == vhfs_pkg::HDR_MAGIC
                && !zero_field && !fmt_bad && !r_pix_ovf && !r_tot_ovf
                && !({1'b0, r_stream_size} < need)) begin
                r_open <= 1'b1;
                r_next <= '0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_res <= n_res;
                    case (vhfs_pkg::t_op'(i_in.operation))
                        vhfs_pkg::OP_HDR: begin
                            if (!r_open) begin
                                r_hdr <= {i_in.data_byte, r_hdr[vhfs_pkg::HDR_BITS-1:8]};
                            end
                        end
                        vhfs_pkg::OP_READ: begin
                            if (r_open && r_next < r_total) begin
                                r_offset <= r_offset + r_fbytes;
                                r_acc    <= r_acc + vhfs_pkg::ACC_W'(r_step);
                                r_rem    <= r_acc[63:32];
                                r_quo    <= r_acc[31:0];
                                r_dcnt   <= '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WH: begin
                r_prod <= mul_p;
            end
            S_LO: begin
                r_pix_ovf <= |r_prod[63:62];
                r_fb      <= {r_prod[61:0], 2'b00};
                r_prod    <= mul_p;
            end
            S_HI: begin
                r_plo  <= r_prod;
                r_prod <= mul_p;
            end
            S_SUM: begin
                r_tot     <= tot_sum[63:0];
                r_tot_ovf <= (|r_prod[63:32]) || tot_sum[64];
                r_prod    <= mul_p;
            end
            S_CHK: begin
                r_res <= n_res;
                if (n_res.status == vhfs_pkg::ST_OK) begin
                    r_width  <= w_width;
                    r_height <= w_height;
                    r_num    <= w_num;
                    r_total  <= w_cnt;
                    r_fbytes <= r_fb;
                    r_step   <= r_prod[vhfs_pkg::STEP_W-1:0];
                    r_acc    <= '0;
                    r_offset <= '0;
                end
            end
            S_DIV: begin
                r_rem  <= div_ge ? div_d[31:0] : div_t[31:0];
                r_quo  <= {r_quo[30:0], div_ge};
                r_dcnt <= r_dcnt + 1'b1;
                if (r_dcnt == 5'd31) begin
                    r_res.frame_msec <= {r_quo[30:0], div_ge};
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    r_out <= r_res;
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out.status;
    assign o_out.has_frame    = r_out.has_frame;
    assign o_out.frame_offset = r_out.frame_offset;
    assign o_out.frame_bytes  = r_out.frame_bytes;
    assign o_out.frame_width  = r_out.frame_width;
    assign o_out.frame_height = r_out.frame_height;
    assign o_out.frame_msec   = r_out.frame_msec;

endmodule

// ===== hdl/vhfs_chk.sv =====
// ----------------------------------------------------------------------------
// vhfs_chk
// Port-level checks for the video header frame sequencer, bound to the top.
// ----------------------------------------------------------------------------
module vhfs_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_out_status,
    input logic        i_out_has_frame,
    input logic [63:0] i_out_frame_bytes,
    input logic [31:0] i_out_frame_msec
);

    // ready drops right after an accepted command beat
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command channel ready right after a beat");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_status <= 3'(vhfs_pkg::ST_WRONG)))
        else $error("result status out of range");

    a_frame_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_has_frame |-> (i_out_status == 3'(vhfs_pkg::ST_OK)))
        else $error("frame descriptor without ok status");

    a_pending_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status == 3'(vhfs_pkg::ST_PENDING))
        |-> !i_out_has_frame && (i_out_frame_bytes == '0) && (i_out_frame_msec == '0))
        else $error("pending result carries frame data");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status))
        else $error("stalled result beat changed");

endmodule

bind video_header_frame_sequencer vhfs_chk u_vhfs_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_status       (o_out.status),
    .i_out_has_frame    (o_out.has_frame),
    .i_out_frame_bytes  (o_out.frame_bytes),
    .i_out_frame_msec   (o_out.frame_msec)
);
